// ===== hdl/swp_pkg.sv =====
package swp_pkg;

  localparam int unsigned WIN_DEPTH = 256;
  localparam int unsigned ADDR_W    = $clog2(WIN_DEPTH);
  localparam int unsigned CNT_W     = $clog2(WIN_DEPTH + 1);
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned BIT_W     = $clog2(VAL_W);
  localparam int unsigned P_W       = 17;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned POS_W     = P_W + CNT_W;
  localparam int unsigned PROD_W    = VAL_W + FRAC_W;

  localparam logic [P_W-1:0] P_ONE = P_W'(65536);

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 48;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LO,
    ST_HI_START,
    ST_HI,
    ST_MUL,
    ST_SUM,
    ST_OUT
  } top_state_e;

  typedef enum logic {
    SEL_IDLE,
    SEL_RUN
  } sel_state_e;

  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] rank;
    logic [CNT_W-1:0]  count;
  } sel_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] value;
  } sel_rsp_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
  } ram_rd_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  data;
  } ram_wr_t;

endpackage

// ===== hdl/swp_ram.sv =====
module swp_ram (
  input  logic                                clk_i,
  input  swp_pkg::ram_wr_t                    wr_i,
  input  swp_pkg::ram_rd_t                    rd_i,
  output logic [swp_pkg::VAL_W-1:0]           rdata_o
);

  logic [swp_pkg::VAL_W-1:0] mem_q [swp_pkg::WIN_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.re) begin
      rdata_o <= mem_q[rd_i.addr];
    end
  end

endmodule

// ===== hdl/swp_rank_sel.sv =====
module swp_rank_sel (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  swp_pkg::sel_req_t             req_i,
  output swp_pkg::sel_rsp_t             rsp_o,
  output swp_pkg::ram_rd_t              rd_o,
  input  logic [swp_pkg::VAL_W-1:0]     rdata_i
);

  swp_pkg::sel_state_e             state_q, state_d;
  logic [swp_pkg::CNT_W-1:0]       idx_q;
  logic [swp_pkg::CNT_W-1:0]       cnt_q;
  logic [swp_pkg::CNT_W-1:0]       n_q;
  logic [swp_pkg::ADDR_W-1:0]      k_q, k_d;
  logic [swp_pkg::BIT_W-1:0]       bit_q;
  logic [swp_pkg::VAL_W-1:0]       prefix_q, prefix_d;
  logic                            rvalid_q;
  logic [swp_pkg::VAL_W-1:0]       mask;
  logic                            match;
  logic                            issue;
  logic                            pass_end;
  logic                            bit_set;

  always_comb begin
    mask     = {swp_pkg::VAL_W{1'b1}} << bit_q;
    match    = ((rdata_i ^ prefix_q) & mask) == '0;
    issue    = (state_q == swp_pkg::SEL_RUN) && (idx_q != n_q);
    pass_end = (state_q == swp_pkg::SEL_RUN) && (idx_q == n_q) && !rvalid_q;
    bit_set  = !(cnt_q > {1'b0, k_q});
    prefix_d = prefix_q;
    k_d      = k_q;
    if (bit_set) begin
      prefix_d = prefix_q | (swp_pkg::VAL_W'(1) << bit_q);
      k_d      = k_q - cnt_q[swp_pkg::ADDR_W-1:0];
    end
    state_d = state_q;
    case (state_q)
      swp_pkg::SEL_IDLE: begin
        if (req_i.start) begin
          state_d = swp_pkg::SEL_RUN;
        end
      end
      swp_pkg::SEL_RUN: begin
        if (pass_end && (bit_q == '0)) begin
          state_d = swp_pkg::SEL_IDLE;
        end
      end
      default: state_d = swp_pkg::SEL_IDLE;
    endcase
    rsp_o.done  = pass_end && (bit_q == '0);
    rsp_o.value = prefix_d;
    rd_o.re     = issue;
    rd_o.addr   = idx_q[swp_pkg::ADDR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= swp_pkg::SEL_IDLE;
      idx_q    <= '0;
      cnt_q    <= '0;
      rvalid_q <= 1'b0;
      bit_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == swp_pkg::SEL_IDLE) begin
        idx_q    <= '0;
        cnt_q    <= '0;
        rvalid_q <= 1'b0;
        bit_q    <= swp_pkg::BIT_W'(swp_pkg::VAL_W - 1);
      end else begin
        rvalid_q <= issue;
        if (issue) begin
          idx_q <= idx_q + 1'b1;
        end
        if (rvalid_q && match) begin
          cnt_q <= cnt_q + 1'b1;
        end
        if (pass_end) begin
          idx_q <= '0;
          cnt_q <= '0;
          bit_q <= bit_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == swp_pkg::SEL_IDLE) && req_i.start) begin
      k_q      <= req_i.rank;
      n_q      <= req_i.count;
      prefix_q <= '0;
    end else if (pass_end) begin
      k_q      <= k_d;
      prefix_q <= prefix_d;
    end
  end

  // rank always within the window while a pass runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swp_pkg::SEL_RUN) |-> ({1'b0, k_q} < n_q))
    else $error("rank outside window");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == swp_pkg::SEL_RUN) |-> (cnt_q <= idx_q))
    else $error("match count ahead of scan");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q |-> $past(issue))
    else $error("read data without request");

endmodule

// ===== hdl/sliding_window_percentile_top.sv =====
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tuser req_type, tdata sample, percentile
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata value, count, empty flag
// cfg       in         cfg_we_i, no wait            cfg_wdata_i sampling_enabled
//
// push, clear and an unused code finish as they are accepted; a query on an empty
// window or with sampling off goes straight to ST_OUT
// any other query runs the bit-serial rank search on one memory read port, for one
// rank, or for two when the position has a fraction, over the n held samples
// reset: all control state cleared, window empty, sampling disabled
// a result waiting in the output register holds the next query in its last step
module sliding_window_percentile_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] sample_value, [48:32] percentile_q16
  input  logic [swp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] percentile_value, [40:32] sample_count, [41] window_empty
  output logic [swp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                              cfg_we_i,
  input  logic                              cfg_wdata_i
);

  swp_pkg::top_state_e             state_q, state_d;
  logic                            en_q;
  logic [swp_pkg::CNT_W-1:0]       cnt_q;
  logic [swp_pkg::ADDR_W-1:0]      oldest_q;
  logic [swp_pkg::ADDR_W-1:0]      lower_q;
  logic [swp_pkg::FRAC_W-1:0]      frac_q;
  logic [swp_pkg::VAL_W-1:0]       lo_q, hi_q, res_q;
  logic [swp_pkg::PROD_W-1:0]      prod_q;
  logic [swp_pkg::CNT_W-1:0]       qcnt_q;
  logic                            out_valid_q;
  logic [swp_pkg::OUT_DATA_W-1:0]  out_data_q;

  logic                            accept;
  swp_pkg::req_e                   req;
  logic [swp_pkg::VAL_W-1:0]       sample;
  logic [swp_pkg::P_W-1:0]         p_raw, p_clamp;
  logic [swp_pkg::POS_W-1:0]       pos;
  logic                            q_zero;
  logic                            out_load;

  swp_pkg::sel_req_t               sel_req;
  swp_pkg::sel_rsp_t               sel_rsp;
  swp_pkg::ram_rd_t                ram_rd;
  swp_pkg::ram_wr_t                ram_wr;
  logic [swp_pkg::VAL_W-1:0]       ram_rdata;

  assign s_axis_tready = (state_q == swp_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign req           = swp_pkg::req_e'(s_axis_tuser);
  assign sample        = s_axis_tdata[swp_pkg::VAL_W-1:0];
  assign p_raw         = s_axis_tdata[swp_pkg::VAL_W +: swp_pkg::P_W];
  assign p_clamp       = (p_raw > swp_pkg::P_ONE) ? swp_pkg::P_ONE : p_raw;
  assign pos           = swp_pkg::POS_W'(p_clamp) * swp_pkg::POS_W'(cnt_q - 1'b1);
  assign q_zero        = !en_q || (cnt_q == '0);
  assign out_load      = (state_q == swp_pkg::ST_OUT) && (!out_valid_q || m_axis_tready);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  always_comb begin
    ram_wr.we   = accept && (req == swp_pkg::REQ_PUSH) && en_q;
    ram_wr.addr = oldest_q + cnt_q[swp_pkg::ADDR_W-1:0];
    ram_wr.data = sample;
  end

  always_comb begin
    state_d       = state_q;
    sel_req.start = 1'b0;
    sel_req.rank  = pos[swp_pkg::FRAC_W +: swp_pkg::ADDR_W];
    sel_req.count = cnt_q;
    case (state_q)
      swp_pkg::ST_IDLE: begin
        if (accept && (req == swp_pkg::REQ_QUERY)) begin
          if (q_zero) begin
            state_d = swp_pkg::ST_OUT;
          end else begin
            sel_req.start = 1'b1;
            state_d       = swp_pkg::ST_LO;
          end
        end
      end
      swp_pkg::ST_LO: begin
        if (sel_rsp.done) begin
          state_d = (frac_q != '0) ? swp_pkg::ST_HI_START : swp_pkg::ST_MUL;
        end
      end
      swp_pkg::ST_HI_START: begin
        sel_req.start = 1'b1;
        sel_req.rank  = lower_q + 1'b1;
        state_d       = swp_pkg::ST_HI;
      end
      swp_pkg::ST_HI: begin
        if (sel_rsp.done) begin
          state_d = swp_pkg::ST_MUL;
        end
      end
      swp_pkg::ST_MUL: state_d = swp_pkg::ST_SUM;
      swp_pkg::ST_SUM: state_d = swp_pkg::ST_OUT;
      swp_pkg::ST_OUT: begin
        if (out_load) begin
          state_d = swp_pkg::ST_IDLE;
        end
      end
      default: state_d = swp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swp_pkg::ST_IDLE;
      en_q        <= 1'b0;
      cnt_q       <= '0;
      oldest_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        en_q     <= cfg_wdata_i;
        cnt_q    <= '0;
        oldest_q <= '0;
      end else if (accept && (req == swp_pkg::REQ_CLEAR)) begin
        cnt_q    <= '0;
        oldest_q <= '0;
      end else if (ram_wr.we) begin
        if (cnt_q == swp_pkg::CNT_W'(swp_pkg::WIN_DEPTH)) begin
          oldest_q <= oldest_q + 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (req == swp_pkg::REQ_QUERY)) begin
      lower_q <= pos[swp_pkg::FRAC_W +: swp_pkg::ADDR_W];
      frac_q  <= pos[swp_pkg::FRAC_W-1:0];
      qcnt_q  <= cnt_q;
      res_q   <= '0;
    end
    if ((state_q == swp_pkg::ST_LO) && sel_rsp.done) begin
      lo_q <= sel_rsp.value;
      hi_q <= sel_rsp.value;
    end
    if ((state_q == swp_pkg::ST_HI) && sel_rsp.done) begin
      hi_q <= sel_rsp.value;
    end
    if (state_q == swp_pkg::ST_MUL) begin
      prod_q <= swp_pkg::PROD_W'(hi_q - lo_q) * swp_pkg::PROD_W'(frac_q);
    end
    if (state_q == swp_pkg::ST_SUM) begin
      res_q <= lo_q + prod_q[swp_pkg::FRAC_W +: swp_pkg::VAL_W];
    end
    if (out_load) begin
      out_data_q <= {6'd0, (qcnt_q == '0), qcnt_q, res_q};
    end
  end

  swp_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (ram_wr),
    .rd_i    (ram_rd),
    .rdata_o (ram_rdata)
  );

  swp_rank_sel u_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (sel_req),
    .rsp_o   (sel_rsp),
    .rd_o    (ram_rd),
    .rdata_i (ram_rdata)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= swp_pkg::CNT_W'(swp_pkg::WIN_DEPTH))
    else $error("held count above depth");

  // the ring only rotates once it is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oldest_q != '0) |-> (cnt_q == swp_pkg::CNT_W'(swp_pkg::WIN_DEPTH)))
    else $error("oldest slot moved before window full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_rsp.done |-> ((state_q == swp_pkg::ST_LO) || (state_q == swp_pkg::ST_HI)))
    else $error("rank search finished outside a query");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == swp_pkg::ST_HI) && sel_rsp.done) |-> (sel_rsp.value >= lo_q))
    else $error("upper rank below lower rank");

endmodule

// ===== verif/sliding_window_percentile_checker.sv =====
`timescale 1ns / 1ps

module sliding_window_percentile_checker
  import swp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [1:0]            s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [CNT_W-1:0] count;
    logic             empty;
  } pct_result_t;

  logic [VAL_W-1:0] window_q [WIN_DEPTH];
  int unsigned      head_idx;
  int unsigned      held;
  logic             sampling_on;
  int unsigned      errors;
  pct_result_t      awaited_q [$];

  function automatic logic [VAL_W-1:0] interp_percentile(logic [P_W-1:0] pct);
    bit [VAL_W-1:0]   ranked [$];
    logic [P_W-1:0]   pc;
    longint unsigned  pos;
    longint unsigned  frac;
    int unsigned      lower;
    int unsigned      upper;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    if (held == 0) return '0;
    for (int unsigned i = 0; i < held; i++) begin
      ranked.insert(ranked.size(), window_q[(head_idx + i) % WIN_DEPTH]);
    end
    ranked.sort();
    pc = (pct > P_ONE) ? P_ONE : pct;
    pos = 64'(pc) * 64'(held - 1);
    lower = int'(pos >> FRAC_W);
    frac = pos & 64'hFFFF;
    upper = lower + ((frac != 0) ? 1 : 0);
    if (lower >= held) lower = held - 1;
    if (upper >= held) upper = held - 1;
    lo = ranked[lower];
    hi = ranked[upper];
    return lo + VAL_W'((64'(hi - lo) * frac) >> FRAC_W);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pct_result_t exp_res;
    pct_result_t got_res;
    if (!rst_ni) begin
      head_idx = 0;
      held = 0;
      sampling_on = 1'b0;
      errors = 0;
      awaited_q.delete();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_res.value = m_axis_tdata[31:0];
        got_res.count = m_axis_tdata[40:32];
        got_res.empty = m_axis_tdata[41];
        if (awaited_q.size() == 0) begin
          $error("result with no query outstanding: value %0d count %0d empty %0d",
                 got_res.value, got_res.count, got_res.empty);
          errors++;
        end else begin
          exp_res = awaited_q.pop_front();
          if (got_res.value !== exp_res.value) begin
            $error("percentile_value expected %0d actual %0d", exp_res.value, got_res.value);
            errors++;
          end
          if (got_res.count !== exp_res.count) begin
            $error("sample_count expected %0d actual %0d", exp_res.count, got_res.count);
            errors++;
          end
          if (got_res.empty !== exp_res.empty) begin
            $error("window_empty expected %0d actual %0d", exp_res.empty, got_res.empty);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        case (req_e'(s_axis_tuser))
          REQ_PUSH: begin
            if (sampling_on) begin
              if (held >= WIN_DEPTH) begin
                window_q[head_idx] = s_axis_tdata[31:0];
                head_idx = (head_idx + 1) % WIN_DEPTH;
              end else begin
                window_q[(head_idx + held) % WIN_DEPTH] = s_axis_tdata[31:0];
                held++;
              end
            end
          end
          REQ_QUERY: begin
            exp_res.value = sampling_on ? interp_percentile(s_axis_tdata[48:32]) : '0;
            exp_res.count = CNT_W'(held);
            exp_res.empty = (held == 0);
            awaited_q.insert(awaited_q.size(), exp_res);
          end
          REQ_CLEAR: begin
            head_idx = 0;
            held = 0;
          end
          default: begin
          end
        endcase
      end
      if (cfg_we_i) begin
        sampling_on = cfg_wdata_i;
        head_idx = 0;
        held = 0;
      end
      fail_count_o <= errors;
      pending_o <= awaited_q.size();
    end
  end

endmodule

// ===== verif/sliding_window_percentile_top_tb.sv =====
`timescale 1ns / 1ps

module sliding_window_percentile_top_tb;
  import swp_pkg::*;

  localparam int unsigned STALL_LIMIT = 100000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned ITEM_TARGET = 1100;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [1:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i;
  logic                  cfg_wdata_i;
  int unsigned           fail_count;
  int unsigned           pending;

  int unsigned items_done;
  int unsigned idle_cycles;
  int unsigned src_calm;
  int unsigned snk_calm;
  int unsigned fills;
  logic        sampling_set;

  sliding_window_percentile_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  sliding_window_percentile_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // random wait per transaction, with occasional back-to-back stretches
  task automatic pick_wait(inout int unsigned calm, output int unsigned cycles);
    if (calm > 0) begin
      calm--;
      cycles = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      cycles = 0;
    end else begin
      cycles = $urandom_range(0, 17);
    end
  endtask

  task automatic send_req(req_e kind, logic [31:0] smp, logic [P_W-1:0] pct);
    int unsigned gap;
    pick_wait(src_calm, gap);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, pct, smp};
    s_axis_tuser <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    items_done++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_sampling(logic en);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= en;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sampling_set = en;
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 7));
      1: return 32'hFFFF_FFFF - 32'($urandom_range(0, 7));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [P_W-1:0] pick_fraction();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return P_ONE;
      2: return P_W'($urandom_range(65537, 131071));
      3: return P_W'($urandom);
      default: return P_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic run_burst();
    int unsigned n_push;
    int unsigned sel;
    if ($urandom_range(0, 3) != 0) send_req(REQ_CLEAR, $urandom, P_W'($urandom));
    sel = $urandom_range(0, 29);
    if (sel == 0 && fills < 2 && sampling_set) begin
      n_push = $urandom_range(256, 320);
      fills++;
    end else if (sel < 6) begin
      n_push = $urandom_range(13, 40);
    end else begin
      n_push = $urandom_range(0, 12);
    end
    repeat (n_push) begin
      if ($urandom_range(0, 15) == 0) send_req(REQ_NONE, $urandom, P_W'($urandom));
      send_req(REQ_PUSH, pick_sample(), P_W'($urandom));
    end
    repeat ($urandom_range(1, 3)) send_req(REQ_QUERY, $urandom, pick_fraction());
  endtask

  initial begin
    int unsigned phase_mark;
    int unsigned phase_len;
    logic        en;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = REQ_PUSH;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    items_done = 0;
    src_calm = 0;
    fills = 0;
    sampling_set = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // sampling off: pushes dropped, queries answer zero
    write_sampling(1'b0);
    send_req(REQ_QUERY, '0, P_ONE);
    send_req(REQ_PUSH, 32'hFFFF_FFFF, '0);
    send_req(REQ_QUERY, '0, 17'd32768);

    write_sampling(1'b1);
    send_req(REQ_QUERY, '0, '0);
    send_req(REQ_PUSH, 32'd0, '0);
    send_req(REQ_PUSH, 32'hFFFF_FFFF, '0);
    send_req(REQ_PUSH, 32'd5, '0);
    send_req(REQ_QUERY, '0, '0);
    send_req(REQ_QUERY, '0, P_ONE);
    send_req(REQ_QUERY, '0, 17'd32768);
    send_req(REQ_QUERY, '0, 17'h1FFFF);
    send_req(REQ_QUERY, '0, 17'd1);
    send_req(REQ_NONE, 32'hFFFF_FFFF, 17'h1FFFF);
    send_req(REQ_CLEAR, '0, '0);
    send_req(REQ_QUERY, '0, 17'd40000);
    send_req(REQ_PUSH, 32'd7, '0);
    send_req(REQ_QUERY, '0, 17'd12345);
    send_req(REQ_QUERY, '0, 17'h1FFFF);
    send_req(REQ_PUSH, 32'd1000, '0);
    send_req(REQ_QUERY, '0, 17'd49152);

    for (int unsigned ph = 0; items_done < ITEM_TARGET; ph++) begin
      en = (ph % 3 != 1);
      write_sampling(en);
      phase_len = en ? 150 : 40;
      phase_mark = items_done;
      while (items_done < phase_mark + phase_len && items_done < ITEM_TARGET) run_burst();
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("sliding_window_percentile_top_tb passed");
    end else begin
      $display("sliding_window_percentile_top_tb failed");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    snk_calm = 0;
    wait (rst_ni);
    forever begin
      pick_wait(snk_calm, stall);
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("sliding_window_percentile_top_tb failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

endmodule
